@@ rtl/core/recent_id_mru_list_top_macros.svh @@
// Assertion macros for the recent identifier list.
// Included by the top level; depends on nothing else.
`ifndef RECENT_ID_MRU_LIST_TOP_MACROS_SVH
`define RECENT_ID_MRU_LIST_TOP_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define RIM_ASSERT_NOW(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error(msg);

// Next-cycle implication, checked on every rising clock edge out of reset.
`define RIM_ASSERT_NEXT(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);

`endif

@@ rtl/core/rim_pkg.sv @@
// Shared constants, types and helper functions for the recent identifier list.
// Used by every module of the block but rim_ram; depends on nothing.
package rim_pkg;

    localparam int LIST_DEPTH = 12;
    localparam int ID_BYTES   = 16;
    localparam int ID_CHARS   = ID_BYTES - 1;
    localparam int ID_BITS    = 8 * ID_CHARS;
    localparam int HEAD_W     = 64;
    localparam int TAIL_W     = ID_BITS - HEAD_W;
    localparam int ADDR_W     = $clog2(LIST_DEPTH);
    localparam int CNT_W      = 4;
    localparam int IDX_W      = 4;

    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;
    localparam logic [7:0] CH_DIGIT_0 = 8'h30;
    localparam logic [7:0] CH_DIGIT_9 = 8'h39;

    typedef enum logic {
        OP_TOUCH = 1'b0,
        OP_READ  = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        STAT_OK     = 2'd0,
        STAT_BAD_ID = 2'd1,
        STAT_RANGE  = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_WALK,
        S_APPEND,
        S_FETCH
    } state_t;

    typedef struct packed {
        logic               valid;
        logic [ID_BITS-1:0] canon;
    } id_chk_t;

    typedef struct packed {
        logic               we;
        logic [ADDR_W-1:0]  waddr;
        logic [ID_BITS-1:0] wdata;
        logic [ADDR_W-1:0]  raddr;
    } ram_req_t;

    function automatic logic is_alnum(input logic [7:0] c);
        return ((c >= CH_UPPER_A) && (c <= CH_UPPER_Z)) ||
               ((c >= CH_LOWER_A) && (c <= CH_LOWER_Z)) ||
               ((c >= CH_DIGIT_0) && (c <= CH_DIGIT_9));
    endfunction

endpackage

@@ rtl/core/rim_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// Self-contained; no package dependency.
module rim_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/core/rim_id_check.sv @@
// Identifier checker: validates an identifier and clears bytes after its terminator.
// Depends on rim_pkg.
module rim_id_check (
    input  logic [rim_pkg::ID_BITS-1:0] id,
    output rim_pkg::id_chk_t            chk
);

    logic [rim_pkg::ID_CHARS-1:0] zero_byte;
    logic [rim_pkg::ID_CHARS-1:0] live;
    logic [rim_pkg::ID_CHARS-1:0] bad_byte;
    logic [rim_pkg::ID_BITS-1:0]  canon;

    always_comb
    begin
        logic [7:0]                   b;
        logic [rim_pkg::ID_CHARS-1:0] below;
        zero_byte = '0;
        live      = '0;
        bad_byte  = '0;
        canon     = '0;
        for (int k = 0; k < rim_pkg::ID_CHARS; k++)
        begin
            zero_byte[k] = (id[rim_pkg::ID_BITS-1-8*k -: 8] == 8'h00);
        end
        for (int k = 0; k < rim_pkg::ID_CHARS; k++)
        begin
            b     = id[rim_pkg::ID_BITS-1-8*k -: 8];
            below = (rim_pkg::ID_CHARS'(1) << k) - rim_pkg::ID_CHARS'(1);
            live[k]     = ~|(zero_byte & below);
            bad_byte[k] = live[k] && !zero_byte[k] && !rim_pkg::is_alnum(b);
            canon[rim_pkg::ID_BITS-1-8*k -: 8] = live[k] ? b : 8'h00;
        end
    end

    assign chk.valid = !zero_byte[0] && !(|bad_byte);
    assign chk.canon = canon;

endmodule

@@ rtl/core/rim_ctrl.sv @@
// Sequencer of the recent identifier list: walks the stored entries through one
// shared identifier comparator. Depends on rim_pkg.
module rim_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        opcode,
    input  logic [rim_pkg::ID_BITS-1:0] id,
    input  logic [rim_pkg::IDX_W-1:0]   read_index,
    output logic [rim_pkg::ID_BITS-1:0] check_id,
    input  rim_pkg::id_chk_t            chk,
    output rim_pkg::ram_req_t           ram_req,
    input  logic [rim_pkg::ID_BITS-1:0] rd_data,
    output logic                        done,
    output logic [1:0]                  status,
    output logic [rim_pkg::CNT_W-1:0]   entry_count,
    output logic [rim_pkg::ID_BITS-1:0] entry_id
);

    rim_pkg::state_t             state_reg, state_next;
    logic [rim_pkg::CNT_W-1:0]   count_reg, count_next;
    logic                        done_reg, done_next;
    rim_pkg::op_t                op_reg, op_next;
    logic [rim_pkg::ID_BITS-1:0] key_reg, key_next;
    logic [rim_pkg::ID_BITS-1:0] carry_reg, carry_next;
    logic [rim_pkg::IDX_W-1:0]   idx_reg, idx_next;
    logic [rim_pkg::ADDR_W-1:0]  pos_reg, pos_next;
    rim_pkg::status_t            status_reg, status_next;
    logic [rim_pkg::CNT_W-1:0]   ocount_reg, ocount_next;
    logic [rim_pkg::ID_BITS-1:0] oid_reg, oid_next;

    logic match;
    logic last;
    logic full;
    logic in_range;

    assign match    = (rd_data == key_reg);
    assign last     = (pos_reg == rim_pkg::ADDR_W'(count_reg - rim_pkg::CNT_W'(1)));
    assign full     = (count_reg == rim_pkg::CNT_W'(rim_pkg::LIST_DEPTH));
    assign in_range = (rim_pkg::CNT_W'(idx_reg) < count_reg);
    assign check_id = key_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rim_pkg::S_IDLE:
            begin
                if (start)
                begin
                    state_next = rim_pkg::S_CHECK;
                end
            end
            rim_pkg::S_CHECK:
            begin
                if (op_reg == rim_pkg::OP_READ)
                begin
                    state_next = in_range ? rim_pkg::S_FETCH : rim_pkg::S_IDLE;
                end
                else if (!chk.valid)
                begin
                    state_next = rim_pkg::S_IDLE;
                end
                else if (count_reg == '0)
                begin
                    state_next = rim_pkg::S_APPEND;
                end
                else
                begin
                    state_next = rim_pkg::S_WALK;
                end
            end
            rim_pkg::S_WALK:
            begin
                if (match)
                begin
                    state_next = rim_pkg::S_IDLE;
                end
                else if (last)
                begin
                    state_next = full ? rim_pkg::S_IDLE : rim_pkg::S_APPEND;
                end
            end
            rim_pkg::S_APPEND:
            begin
                state_next = rim_pkg::S_IDLE;
            end
            rim_pkg::S_FETCH:
            begin
                state_next = rim_pkg::S_IDLE;
            end
            default:
            begin
                state_next = rim_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        count_next  = count_reg;
        done_next   = 1'b0;
        op_next     = op_reg;
        key_next    = key_reg;
        carry_next  = carry_reg;
        idx_next    = idx_reg;
        pos_next    = pos_reg;
        status_next = status_reg;
        ocount_next = ocount_reg;
        oid_next    = oid_reg;
        busy        = (state_reg != rim_pkg::S_IDLE);
        ram_req     = '0;
        unique case (state_reg)
            rim_pkg::S_IDLE:
            begin
                if (start)
                begin
                    op_next  = rim_pkg::op_t'(opcode);
                    key_next = id;
                    idx_next = read_index;
                end
            end
            rim_pkg::S_CHECK:
            begin
                if (op_reg == rim_pkg::OP_READ)
                begin
                    ram_req.raddr = rim_pkg::ADDR_W'(idx_reg);
                    if (!in_range)
                    begin
                        done_next   = 1'b1;
                        status_next = rim_pkg::STAT_RANGE;
                        ocount_next = count_reg;
                        oid_next    = '0;
                    end
                end
                else if (!chk.valid)
                begin
                    done_next   = 1'b1;
                    status_next = rim_pkg::STAT_BAD_ID;
                    ocount_next = count_reg;
                    oid_next    = '0;
                end
                else
                begin
                    key_next   = chk.canon;
                    carry_next = chk.canon;
                    pos_next   = '0;
                end
            end
            rim_pkg::S_WALK:
            begin
                ram_req.we    = 1'b1;
                ram_req.waddr = pos_reg;
                ram_req.wdata = carry_reg;
                ram_req.raddr = last ? pos_reg : pos_reg + rim_pkg::ADDR_W'(1);
                carry_next    = rd_data;
                pos_next      = pos_reg + rim_pkg::ADDR_W'(1);
                if (match || (last && full))
                begin
                    done_next   = 1'b1;
                    status_next = rim_pkg::STAT_OK;
                    ocount_next = count_reg;
                    oid_next    = '0;
                end
            end
            rim_pkg::S_APPEND:
            begin
                ram_req.we    = 1'b1;
                ram_req.waddr = pos_reg;
                ram_req.wdata = carry_reg;
                count_next    = count_reg + rim_pkg::CNT_W'(1);
                done_next     = 1'b1;
                status_next   = rim_pkg::STAT_OK;
                ocount_next   = count_reg + rim_pkg::CNT_W'(1);
                oid_next      = '0;
            end
            rim_pkg::S_FETCH:
            begin
                done_next   = 1'b1;
                status_next = rim_pkg::STAT_OK;
                ocount_next = count_reg;
                oid_next    = rd_data;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rim_pkg::S_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        key_reg    <= key_next;
        carry_reg  <= carry_next;
        idx_reg    <= idx_next;
        pos_reg    <= pos_next;
        status_reg <= status_next;
        ocount_reg <= ocount_next;
        oid_reg    <= oid_next;
    end

    assign done        = done_reg;
    assign status      = status_reg;
    assign entry_count = ocount_reg;
    assign entry_id    = oid_reg;

endmodule

@@ rtl/core/recent_id_mru_list_top.sv @@
// Top level of the recent identifier list: sequencer, identifier checker and list RAM.
// Depends on rim_pkg, rim_ram, rim_id_check, rim_ctrl and the assertion macro header.
//
// Keeps a move-to-front list of up to twelve identifiers of at most 15 bytes.
// An item is accepted at a rising edge where start is high and busy is low;
// opcode selects a touch (move an identifier to the front) or a read of the
// entry at read_index. Each item gives one result, shown for one cycle with
// done high, carrying status, the entry count after the item and, for a good
// read, the entry bytes. The receiver cannot stall, so results are never held.
// A bad identifier and an out-of-range read are answered from the check state,
// a good read from the fetch state after it. A touch walks the list through
// one identifier comparator, one entry per cycle, until it finds the old copy
// or the end of the list. busy stays high until the result cycle, in which a
// new item may already be accepted. Reset empties the list; the RAM contents
// need no clearing.
`include "recent_id_mru_list_top_macros.svh"

module recent_id_mru_list_top (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic                       opcode,
    input  logic [rim_pkg::HEAD_W-1:0] id_head,
    input  logic [rim_pkg::TAIL_W-1:0] id_tail,
    input  logic [rim_pkg::IDX_W-1:0]  read_index,
    output logic                       done,
    output logic [1:0]                 status,
    output logic [rim_pkg::CNT_W-1:0]  entry_count,
    output logic [rim_pkg::HEAD_W-1:0] entry_head,
    output logic [rim_pkg::TAIL_W-1:0] entry_tail
);

    logic [rim_pkg::ID_BITS-1:0] check_id;
    rim_pkg::id_chk_t            chk;
    rim_pkg::ram_req_t           ram_req;
    logic [rim_pkg::ID_BITS-1:0] rd_data;
    logic [rim_pkg::ID_BITS-1:0] entry_id;

    rim_ram #(
        .WIDTH (rim_pkg::ID_BITS),
        .DEPTH (rim_pkg::LIST_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_req.we),
        .waddr (ram_req.waddr),
        .wdata (ram_req.wdata),
        .raddr (ram_req.raddr),
        .rdata (rd_data)
    );

    rim_id_check u_id_check (
        .id  (check_id),
        .chk (chk)
    );

    rim_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .opcode      (opcode),
        .id          ({id_head, id_tail}),
        .read_index  (read_index),
        .check_id    (check_id),
        .chk         (chk),
        .ram_req     (ram_req),
        .rd_data     (rd_data),
        .done        (done),
        .status      (status),
        .entry_count (entry_count),
        .entry_id    (entry_id)
    );

    assign entry_head = entry_id[rim_pkg::ID_BITS-1 -: rim_pkg::HEAD_W];
    assign entry_tail = entry_id[rim_pkg::TAIL_W-1:0];

    `RIM_ASSERT_NOW(a_count_bound, clk, rst_n, done, entry_count <= rim_pkg::CNT_W'(rim_pkg::LIST_DEPTH), "entry count above list depth")
    `RIM_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, start && !busy, busy && !done, "no busy cycle after an accepted item")
    `RIM_ASSERT_NEXT(a_single_result, clk, rst_n, done, !done, "two results in a row")
    `RIM_ASSERT_NOW(a_error_no_data, clk, rst_n, done && (status != 2'(rim_pkg::STAT_OK)), (entry_head == '0) && (entry_tail == '0), "entry data on an error result")

endmodule
